// ===== src/hfx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfx_pkg
// Types, constants and byte-step functions shared by the HTTP header field
// extractor.
// ----------------------------------------------------------------------------
package hfx_pkg;

    localparam int COL_W    = 5;
    localparam int CNT_W    = 7;
    localparam int TAG_PFX_LEN = 7;
    localparam int LEN_PFX_LEN = 16;
    localparam logic [COL_W-1:0] COL_SAT = 5'd31;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] TAG_PFX [TAG_PFX_LEN] = '{
        8'h45, 8'h54, 8'h61, 8'h67, 8'h3A, 8'h20, 8'h22
    };
    localparam logic [7:0] LEN_PFX [LEN_PFX_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };

    typedef enum logic [1:0] {
        NUM_SKIP   = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_DONE   = 2'd2
    } num_phase_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             tag_alive;
        logic             len_alive;
        logic [CNT_W-1:0] value_count;
        num_phase_t       phase;
        logic             negative;
        logic [31:0]      accum;
    } line_state_t;

    typedef struct packed {
        logic [31:0]      length;
        logic [CNT_W-1:0] count;
        logic             bank;
    } run_info_t;

    localparam line_state_t LINE_CLEAR = '{
        column:      '0,
        tag_alive:   1'b1,
        len_alive:   1'b1,
        value_count: '0,
        phase:       NUM_SKIP,
        negative:    1'b0,
        accum:       '0
    };

    function automatic line_state_t feed_number(line_state_t st, logic [7:0] b);
        line_state_t r;
        logic        digit;
        logic        skip;
        r     = st;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        skip  = 1'b0;
        if (st.phase == NUM_SKIP) begin
            if (b == CH_SPACE || b == CH_TAB) begin
                skip = 1'b1;
            end
            else if (b == CH_PLUS || b == CH_MINUS) begin
                r.negative = (b == CH_MINUS);
                r.phase    = NUM_DIGITS;
                skip       = 1'b1;
            end
            else begin
                r.phase = digit ? NUM_DIGITS : NUM_DONE;
            end
        end
        else if (st.phase == NUM_DIGITS) begin
            if (!digit) begin
                r.phase = NUM_DONE;
            end
        end
        if (!skip && r.phase == NUM_DIGITS && digit) begin
            r.accum = (st.accum << 3) + (st.accum << 1) + {28'd0, b[3:0]};
        end
        return r;
    endfunction

    function automatic line_state_t content_byte(line_state_t st, logic [7:0] b,
                                                 logic [CNT_W-1:0] tag_max);
        line_state_t r;
        r = st;
        if (st.column < COL_W'(TAG_PFX_LEN)) begin
            if (b != TAG_PFX[st.column[2:0]]) begin
                r.tag_alive = 1'b0;
            end
        end
        else if (st.tag_alive) begin
            if (st.value_count <= tag_max) begin
                r.value_count = st.value_count + 1'b1;
            end
        end
        if (st.column < COL_W'(LEN_PFX_LEN)) begin
            if (b != LEN_PFX[st.column[3:0]]) begin
                r.len_alive = 1'b0;
            end
        end
        else if (st.len_alive) begin
            r = feed_number(r, b);
        end
        if (st.column < COL_SAT) begin
            r.column = st.column + 1'b1;
        end
        return r;
    endfunction

    function automatic logic stage_write(line_state_t st, logic [CNT_W-1:0] tag_max);
        return (st.column >= COL_W'(TAG_PFX_LEN)) && st.tag_alive
            && (st.value_count < tag_max);
    endfunction

endpackage

// ===== src/hfx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfx_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/hfx_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfx_line_parser
// Per-byte line tracking, prefix matching, tag staging writes and length
// parsing; hands the finished run to the result reader.
// ----------------------------------------------------------------------------
module hfx_line_parser #(
    parameter int TAG_MAX = 32,
    parameter int IW      = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           header_byte,
    input  logic                 final_byte,
    output logic                 mem_we,
    output logic [IW:0]          mem_waddr,
    output logic [7:0]           mem_wdata,
    output logic                 run_start,
    output hfx_pkg::run_info_t   run_info
);
    import hfx_pkg::*;

    localparam logic [CNT_W-1:0] TMAX = CNT_W'(TAG_MAX);

    logic             cr_pending_reg, cr_pending_next;
    line_state_t      line_reg, line_next;
    logic             bank_reg, bank_next;
    logic [CNT_W-1:0] kept_count_reg, kept_count_next;
    logic [31:0]      length_reg, length_next;

    line_state_t      s1;
    line_state_t      s2;
    line_state_t      wr_state;
    logic             wr_req;
    logic [7:0]       wr_byte;
    logic             line_done;
    logic [CNT_W-1:0] tag_n;

    always_comb
    begin
        s1        = content_byte(line_reg, CH_CR, TMAX);
        s2        = content_byte(s1, header_byte, TMAX);
        line_next = line_reg;
        cr_pending_next = cr_pending_reg;
        wr_req    = 1'b0;
        wr_state  = line_reg;
        wr_byte   = header_byte;
        line_done = 1'b0;
        if (cr_pending_reg)
        begin
            if (header_byte == CH_LF)
            begin
                line_done       = 1'b1;
                line_next       = LINE_CLEAR;
                cr_pending_next = 1'b0;
            end
            else if (header_byte == CH_CR)
            begin
                line_next = s1;
                wr_req    = 1'b1;
                wr_state  = s1;
                wr_byte   = CH_CR;
            end
            else
            begin
                line_next       = s2;
                cr_pending_next = 1'b0;
                wr_req          = 1'b1;
                wr_state        = s1;
            end
        end
        else if (header_byte == CH_CR)
        begin
            cr_pending_next = 1'b1;
            wr_req          = 1'b1;
            wr_state        = line_reg;
            wr_byte         = CH_CR;
        end
        else
        begin
            line_next = content_byte(line_reg, header_byte, TMAX);
            wr_req    = 1'b1;
            wr_state  = line_reg;
        end
    end

    always_comb
    begin
        tag_n = line_reg.value_count - 1'b1;
        if (tag_n > TMAX)
        begin
            tag_n = TMAX;
        end
        bank_next       = bank_reg;
        kept_count_next = kept_count_reg;
        length_next     = length_reg;
        if (line_done)
        begin
            if (line_reg.tag_alive && line_reg.column > COL_W'(TAG_PFX_LEN))
            begin
                bank_next       = ~bank_reg;
                kept_count_next = tag_n;
            end
            else if (line_reg.len_alive && line_reg.column > COL_W'(LEN_PFX_LEN))
            begin
                length_next = line_reg.negative ? (32'd0 - line_reg.accum)
                                                : line_reg.accum;
            end
        end
    end

    assign mem_we    = accept && wr_req && stage_write(wr_state, TMAX);
    assign mem_waddr = {~bank_reg, wr_state.value_count[IW-1:0]};
    assign mem_wdata = wr_byte;

    assign run_start       = accept && final_byte;
    assign run_info.length = length_next;
    assign run_info.count  = kept_count_next;
    assign run_info.bank   = bank_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_pending_reg <= 1'b0;
            line_reg       <= LINE_CLEAR;
            bank_reg       <= 1'b0;
            kept_count_reg <= '0;
            length_reg     <= '0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                cr_pending_reg <= 1'b0;
                line_reg       <= LINE_CLEAR;
                bank_reg       <= bank_next;
                kept_count_reg <= '0;
                length_reg     <= '0;
            end
            else
            begin
                cr_pending_reg <= cr_pending_next;
                line_reg       <= line_next;
                bank_reg       <= bank_next;
                kept_count_reg <= kept_count_next;
                length_reg     <= length_next;
            end
        end
    end

endmodule

// ===== src/hfx_result_reader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfx_result_reader
// Reads the kept tag out of the tag memory, one result per transfer, and
// holds each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module hfx_result_reader #(
    parameter int IW = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               run_start,
    input  hfx_pkg::run_info_t run_info,
    output logic               busy,
    output logic               mem_re,
    output logic [IW:0]        mem_raddr,
    input  logic [7:0]         mem_rdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        length_value,
    output logic [5:0]         tag_length,
    output logic [7:0]         tag_byte,
    output logic               tag_byte_valid,
    output logic               run_end
);
    import hfx_pkg::*;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    run_info_t        run_reg;
    logic             ovalid_reg, ovalid_next;
    logic [31:0]      olen_reg;
    logic [5:0]       otlen_reg;
    logic             obv_reg;
    logic             olast_reg;
    logic             advance;
    logic             issue;
    logic             last_idx;

    assign advance  = !ovalid_reg || out_ready;
    assign issue    = busy_reg && advance;
    assign last_idx = (idx_reg + 1'b1) == run_reg.count;

    assign mem_re    = issue && (run_reg.count != '0);
    assign mem_raddr = {run_reg.bank, idx_reg[IW-1:0]};

    always_comb
    begin
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        if (issue)
        begin
            ovalid_next = 1'b1;
            idx_next    = idx_reg + 1'b1;
            if (run_reg.count == '0 || last_idx)
            begin
                busy_next = 1'b0;
            end
        end
        else if (advance)
        begin
            ovalid_next = 1'b0;
        end
        if (run_start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_start)
        begin
            run_reg <= run_info;
        end
        if (issue)
        begin
            olen_reg  <= run_reg.length;
            otlen_reg <= 6'(run_reg.count);
            obv_reg   <= (run_reg.count != '0);
            olast_reg <= (run_reg.count == '0) || last_idx;
        end
    end

    assign busy           = busy_reg;
    assign out_valid      = ovalid_reg;
    assign length_value   = olen_reg;
    assign tag_length     = otlen_reg;
    assign tag_byte       = obv_reg ? mem_rdata : 8'd0;
    assign tag_byte_valid = obv_reg;
    assign run_end        = olast_reg;

endmodule

// ===== src/http_header_field_extractor_top.sv =====
`timescale 1ns / 1ps
// An accepted final byte starts the result reader, which then reads the tag memory.
// Throughput: one header byte per cycle while not busy; results leave one per cycle
// while m_axis_tready is high, up to TAG_MAX. Input is held from the final byte until
// the last tag memory read of its run is issued.
// Reset: asynchronous, clears control state; the tag memory is not cleared.
// ----------------------------------------------------------------------------
// http_header_field_extractor_top
// Extracts the entity tag and content length from a response header stream.
// ----------------------------------------------------------------------------
module http_header_field_extractor_top #(
    parameter int TAG_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] header_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] length_value, [37:32] tag_length,
                                        // [45:38] tag_byte, [47:46] zero
    output logic        m_axis_tuser,   // [0] tag_byte_valid
    output logic        m_axis_tlast
);
    import hfx_pkg::*;

    localparam int IW    = (TAG_MAX > 1) ? $clog2(TAG_MAX) : 1;
    localparam int DEPTH = 2 * (2 ** IW);

    logic        accept;
    logic        busy;
    logic        mem_we;
    logic [IW:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_re;
    logic [IW:0] mem_raddr;
    logic [7:0]  mem_rdata;
    logic        run_start;
    run_info_t   run_info;
    logic [31:0] length_value;
    logic [5:0]  tag_length;
    logic [7:0]  tag_byte;

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && !busy;

    hfx_line_parser #(
        .TAG_MAX (TAG_MAX),
        .IW      (IW)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .header_byte (s_axis_tdata),
        .final_byte  (s_axis_tlast),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .run_start   (run_start),
        .run_info    (run_info)
    );

    hfx_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hfx_result_reader #(
        .IW (IW)
    ) u_reader (
        .clk            (clk),
        .rst_n          (rst_n),
        .run_start      (run_start),
        .run_info       (run_info),
        .busy           (busy),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .length_value   (length_value),
        .tag_length     (tag_length),
        .tag_byte       (tag_byte),
        .tag_byte_valid (m_axis_tuser),
        .run_end        (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, tag_byte, tag_length, length_value};

endmodule

// ===== verif/http_header_field_extractor_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_field_extractor_top_tb
// Streams response header blocks into the extractor and checks every result
// transfer against a cycle-free predictor of the tag and length parsing.
// Directed blocks cover tag, length and line-ending corner cases; random
// blocks run under three idle patterns, plus a long output stall.
// ----------------------------------------------------------------------------
module http_header_field_extractor_top_tb;

    import hfx_pkg::*;

    localparam int TAG_LIMIT    = 32;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 30;
    localparam int PHASE_BEATS  = 5;

    typedef struct packed {
        logic [31:0] length;
        logic [5:0]  tag_len;
        logic [7:0]  tag_byte;
        logic        tag_valid;
        logic        run_end;
    } tag_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] header_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [31:0] length_value, [37:32] tag_length,
                                 // [45:38] tag_byte, [47:46] zero
    logic        m_axis_tuser;   // [0] tag_byte_valid
    logic        m_axis_tlast;

    tag_beat_t   beat_q[$];
    logic [7:0]  run_q[$];

    int          errors;
    int          bytes_sent;
    int          runs_sent;
    int          beats_seen;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold_cycles;

    // header parser shadow
    logic        cr_wait;
    logic [4:0]  line_col;
    logic        tag_live;
    logic        len_live;
    logic [6:0]  stage_cnt;
    logic [7:0]  stage_mem [TAG_LIMIT];
    logic [7:0]  kept_mem [TAG_LIMIT];
    logic [6:0]  kept_cnt;
    num_phase_t  num_phase;
    logic        num_neg;
    logic [31:0] num_acc;
    logic [31:0] len_kept;

    http_header_field_extractor_top #(
        .TAG_MAX(TAG_LIMIT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic clear_line();
        line_col  = '0;
        tag_live  = 1'b1;
        len_live  = 1'b1;
        stage_cnt = '0;
        num_phase = NUM_SKIP;
        num_neg   = 1'b0;
        num_acc   = '0;
    endtask

    task automatic clear_parser();
        cr_wait  = 1'b0;
        clear_line();
        kept_cnt = '0;
        len_kept = '0;
    endtask

    task automatic scan_number(input logic [7:0] b);
        logic digit;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        if (num_phase == NUM_SKIP)
        begin
            if (b == CH_SPACE || b == CH_TAB)
                return;
            if (b == CH_PLUS || b == CH_MINUS)
            begin
                num_neg   = (b == CH_MINUS);
                num_phase = NUM_DIGITS;
                return;
            end
            num_phase = digit ? NUM_DIGITS : NUM_DONE;
        end
        else if (num_phase == NUM_DIGITS)
        begin
            if (!digit)
                num_phase = NUM_DONE;
        end
        if (num_phase == NUM_DIGITS && digit)
            num_acc = num_acc * 32'd10 + {28'd0, b[3:0]};
    endtask

    task automatic take_line_byte(input logic [7:0] b);
        if (int'(line_col) < TAG_PFX_LEN)
        begin
            if (b != TAG_PFX[line_col[2:0]])
                tag_live = 1'b0;
        end
        else if (tag_live)
        begin
            if (int'(stage_cnt) < TAG_LIMIT)
                stage_mem[stage_cnt[4:0]] = b;
            if (int'(stage_cnt) < TAG_LIMIT + 1)
                stage_cnt = stage_cnt + 7'd1;
        end
        if (int'(line_col) < LEN_PFX_LEN)
        begin
            if (b != LEN_PFX[line_col[3:0]])
                len_live = 1'b0;
        end
        else if (len_live)
        begin
            scan_number(b);
        end
        if (line_col < COL_SAT)
            line_col = line_col + 5'd1;
    endtask

    task automatic close_line();
        int n;
        if (tag_live && int'(line_col) > TAG_PFX_LEN)
        begin
            n = int'(stage_cnt) - 1;
            if (n > TAG_LIMIT)
                n = TAG_LIMIT;
            for (int i = 0; i < n; i++)
                kept_mem[i] = stage_mem[i];
            kept_cnt = 7'(n);
        end
        else if (len_live && int'(line_col) > LEN_PFX_LEN)
        begin
            len_kept = num_neg ? (32'd0 - num_acc) : num_acc;
        end
        clear_line();
    endtask

    task automatic predict_transfer(input logic [7:0] b, input logic fin);
        tag_beat_t beat;
        if (cr_wait)
        begin
            cr_wait = 1'b0;
            if (b == CH_LF)
            begin
                close_line();
            end
            else
            begin
                take_line_byte(CH_CR);
                if (b == CH_CR)
                    cr_wait = 1'b1;
                else
                    take_line_byte(b);
            end
        end
        else if (b == CH_CR)
        begin
            cr_wait = 1'b1;
        end
        else
        begin
            take_line_byte(b);
        end
        if (!fin)
            return;
        if (kept_cnt == '0)
        begin
            beat = '{length: len_kept, tag_len: '0, tag_byte: '0, tag_valid: 1'b0,
                     run_end: 1'b1};
            beat_q.push_back(beat);
        end
        else
        begin
            for (int k = 0; k < int'(kept_cnt); k++)
            begin
                beat = '{length: len_kept, tag_len: kept_cnt[5:0], tag_byte: kept_mem[k],
                         tag_valid: 1'b1, run_end: (k + 1 == int'(kept_cnt))};
                beat_q.push_back(beat);
            end
        end
        clear_parser();
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tag_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_seen++;
            if (beat_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer expected none actual tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = beat_q.pop_front();
                check_field("length_value", want.length, m_axis_tdata[31:0]);
                check_field("tag_length", 32'(want.tag_len), 32'(m_axis_tdata[37:32]));
                check_field("tag_byte", 32'(want.tag_byte), 32'(m_axis_tdata[45:38]));
                check_field("tdata pad", 32'd0, 32'(m_axis_tdata[47:46]));
                check_field("tag_byte_valid", 32'(want.tag_valid), 32'(m_axis_tuser));
                check_field("run_end", 32'(want.run_end), 32'(m_axis_tlast));
            end
        end
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    task automatic offer_header_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_transfer(b, fin);
        bytes_sent++;
    endtask

    task automatic send_run();
        for (int i = 0; i < run_q.size(); i++)
            offer_header_byte(run_q[i], i == run_q.size() - 1);
        runs_sent++;
        run_q.delete();
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (beat_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            run_q.push_back(s[i]);
    endtask

    task automatic end_line();
        run_q.push_back(CH_CR);
        run_q.push_back(CH_LF);
    endtask

    task automatic push_tag_body(input int n);
        repeat (n)
            run_q.push_back(($urandom_range(9) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(8'h21, 8'h7E)));
    endtask

    task automatic add_random_line();
        int    kind;
        int    n;
        string pfx;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            push_text("ETag: \"");
            n = $urandom_range(99);
            push_tag_body((n < 60) ? $urandom_range(8) :
                          (n < 90) ? $urandom_range(9, 31) : $urandom_range(32, 45));
            run_q.push_back(8'h22);
        end
        else if (kind < 65)
        begin
            push_text("Content-Length: ");
            repeat ($urandom_range(2))
                run_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            n = $urandom_range(99);
            if (n < 15)
                run_q.push_back(CH_PLUS);
            else if (n < 30)
                run_q.push_back(CH_MINUS);
            repeat ($urandom_range(12))
                run_q.push_back(CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(3) == 0)
                run_q.push_back(8'($urandom));
        end
        else if (kind < 75)
        begin
            pfx = $urandom_range(1) ? "ETag: \"" : "Content-Length: ";
            n   = $urandom_range(pfx.len() - 1);
            for (int i = 0; i < pfx.len(); i++)
            begin
                b = pfx[i];
                if (i == n)
                    b = b ^ 8'(1 << $urandom_range(7));
                run_q.push_back(b);
            end
            push_tag_body($urandom_range(6));
        end
        else
        begin
            repeat ($urandom_range(20))
                run_q.push_back(8'($urandom));
        end
        n = $urandom_range(99);
        if (n < 80)
        begin
            end_line();
        end
        else if (n < 90)
        begin
            run_q.push_back(CH_CR);
            end_line();
        end
    endtask

    task automatic build_random_header();
        run_q.delete();
        if ($urandom_range(9) != 0)
            repeat ($urandom_range(1, 4))
                add_random_line();
        if ($urandom_range(9) < 3)
            repeat ($urandom_range(1, 4))
                run_q.push_back(($urandom_range(3) == 0) ? CH_CR : 8'($urandom));
        if (run_q.size() == 0)
            run_q.push_back(8'($urandom));
    endtask

    task automatic test_bare_bytes();
        run_q.push_back(8'h00);
        send_run();
        run_q.push_back(8'hFF);
        send_run();
    endtask

    task automatic test_entity_tag();
        push_text("ETag: \"ab\"");
        end_line();
        send_run();
        push_text("ETag: \"\"");
        end_line();
        send_run();
        push_text("ETag: \"");
        run_q.push_back(8'h00);
        run_q.push_back(8'hFF);
        push_tag_body(36);
        run_q.push_back(8'h00);
        run_q.push_back(8'h22);
        end_line();
        send_run();
        push_text("ETag: \"a");
        run_q.push_back(CH_CR);
        push_text("b\"");
        run_q.push_back(CH_CR);
        end_line();
        send_run();
        push_text("etag: \"x\"");
        end_line();
        push_text("ETag: \"");
        end_line();
        send_run();
    endtask

    task automatic test_content_length();
        push_text("Content-Length: 123");
        end_line();
        send_run();
        push_text("Content-Length: ");
        run_q.push_back(CH_TAB);
        push_text(" -42x");
        end_line();
        send_run();
        push_text("Content-Length: +4294967296");
        end_line();
        push_text("Content-Length: 99999999999");
        end_line();
        send_run();
        push_text("Content-Length: 7");
        end_line();
        push_text("Content-Length: ");
        end_line();
        send_run();
        push_text("Content-Length: abc");
        end_line();
        send_run();
    endtask

    task automatic test_line_endings();
        push_text("ETag: \"zz\"");
        run_q.push_back(CH_CR);
        send_run();
        push_text("ETag: \"first\"");
        end_line();
        push_text("Content-Length: 10");
        end_line();
        push_text("ETag: \"second\"");
        end_line();
        push_text("ETag: \"qq\"");
        run_q.push_back(CH_LF);
        push_text("Content-Length: 9");
        send_run();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        int byte_mark;
        int beat_mark;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        byte_mark   = bytes_sent;
        beat_mark   = beats_seen + beat_q.size();
        while (bytes_sent - byte_mark < PHASE_BYTES
               || beats_seen + beat_q.size() - beat_mark < PHASE_BEATS)
        begin
            build_random_header();
            send_run();
        end
        wait_drain();
    endtask

    task automatic test_output_stall();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 300;
        repeat (2)
        begin
            push_text("ETag: \"");
            push_tag_body(TAG_LIMIT);
            run_q.push_back(8'h22);
            end_line();
            push_text("Content-Length: 5");
            end_line();
            send_run();
        end
        wait_drain();
    endtask

    initial
    begin
        errors         = 0;
        bytes_sent     = 0;
        runs_sent      = 0;
        beats_seen     = 0;
        tx_idle_pct    = 11;
        rx_idle_pct    = 55;
        rx_hold_cycles = 0;
        clear_parser();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bare_bytes();
        test_entity_tag();
        test_content_length();
        test_line_endings();
        wait_drain();
        test_random_traffic(11, 55);
        test_random_traffic(55, 11);
        test_random_traffic(0, 0);
        test_output_stall();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (beat_q.size() != 0)
        begin
            errors += beat_q.size();
            $display("%0t: results left over expected 0 actual %0d", $time, beat_q.size());
        end
        $display("Sent %0d header bytes in %0d blocks, checked %0d result transfers.",
                 bytes_sent, runs_sent, beats_seen);
        $display("Covered tags, lengths, CR/LF corners, idle patterns and a long output stall.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
